>>> design/vrt_pkg.sv
// Shared types, codes and sizes for the visit record table.
package vrt_pkg;

	localparam int CAPACITY  = 1024;
	localparam int KEY_BITS  = 64;
	localparam int ADDR_W    = $clog2(CAPACITY);
	localparam int OCC_W     = $clog2(CAPACITY + 1);
	localparam int REMOVED_W = 11;
	localparam int SIZE_W    = 48;
	localparam int TIME_W    = 32;
	localparam int MAX_W     = 11;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 32;

	// Operation codes
	localparam logic [2:0] MODE_ADD    = 3'd0;
	localparam logic [2:0] MODE_LOOKUP = 3'd1;
	localparam logic [2:0] MODE_AGE    = 3'd2;
	localparam logic [2:0] MODE_HEUR   = 3'd3;
	localparam logic [2:0] MODE_CLEAR  = 3'd4;

	// Result status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_FULL     = 2'd1;
	localparam logic [1:0] STATUS_NOTFOUND = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_THR  = 1'd1;

	typedef struct packed {
		logic [2:0]        mode;
		logic [63:0]       fingerprint;
		logic [SIZE_W-1:0] content_size;
		logic              content_known;
		logic [TIME_W-1:0] modified_time;
		logic              modified_known;
		logic [TIME_W-1:0] write_time;
		logic              write_known;
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] cutoff;
	} req_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [TIME_W-1:0]    first_seen;
		logic [TIME_W-1:0]    access_time;
		logic [TIME_W-1:0]    access_count;
		logic [TIME_W-1:0]    change_count;
		logic [TIME_W-1:0]    change_time;
		logic [SIZE_W-1:0]    last_size;
		logic [REMOVED_W-1:0] removed_count;
	} rsp_t;

	typedef struct packed {
		logic                valid;
		logic [KEY_BITS-1:0] key;
		logic [TIME_W-1:0]   first_seen;
		logic [TIME_W-1:0]   access_time;
		logic [TIME_W-1:0]   access_count;
		logic [TIME_W-1:0]   change_count;
		logic [TIME_W-1:0]   change_time;
		logic [SIZE_W-1:0]   last_size;
	} entry_t;

	typedef enum logic [3:0] {
		ST_WIPE,
		ST_IDLE,
		ST_DISPATCH,
		ST_SCAN,
		ST_DRAIN,
		ST_APPLY,
		ST_COMMIT,
		ST_HCHECK,
		ST_HTARGET,
		ST_CLEAR,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_FIND,
		KIND_SWEEP,
		KIND_MIN
	} scan_kind_t;

	typedef struct packed {
		logic              idle;
		logic              load;
		logic              scan_init;
		logic              rd_en;
		logic              clr_wr;
		logic [ADDR_W-1:0] addr;
		scan_kind_t        kind;
		logic              set_cut;
		logic              set_heur;
		logic              commit;
		logic              apply;
		logic              clear_commit;
		logic              finish;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       cut_gt;
		logic       over;
		logic       off_zero;
		logic       ac_max;
		logic       rsp_busy;
	} dp_sts_t;

endpackage

>>> design/vrt_ctrl.sv
// Sequencer for the visit record table: scans, commits and result hand-off.
module vrt_ctrl
	import vrt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	state_t            state_q, state_d;
	logic [ADDR_W-1:0] scan_q, scan_d;
	scan_kind_t        kind_q, kind_d;
	logic              last;

	assign last = (scan_q == ADDR_W'(CAPACITY - 1));

	// State, scan address and scan kind registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_WIPE;
			scan_q  <= '0;
			kind_q  <= KIND_NONE;
		end else begin
			state_q <= state_d;
			scan_q  <= scan_d;
			kind_q  <= kind_d;
		end
	end

	// Next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		scan_d  = scan_q;
		kind_d  = kind_q;
		unique case (state_q)
			ST_WIPE: begin
				cmd.clr_wr = 1'b1;
				cmd.addr   = scan_q;
				if (last) begin
					scan_d  = '0;
					state_d = ST_IDLE;
				end else begin
					scan_d = scan_q + 1'b1;
				end
			end
			ST_IDLE: begin
				cmd.idle = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				scan_d = '0;
				case (sts.mode)
					MODE_ADD, MODE_LOOKUP: begin
						cmd.scan_init = 1'b1;
						kind_d        = KIND_FIND;
						state_d       = ST_SCAN;
					end
					MODE_AGE: begin
						if (sts.cut_gt) begin
							cmd.set_cut   = 1'b1;
							cmd.scan_init = 1'b1;
							kind_d        = KIND_SWEEP;
							state_d       = ST_SCAN;
						end else begin
							state_d = ST_FIN;
						end
					end
					MODE_HEUR:  state_d = ST_HCHECK;
					MODE_CLEAR: state_d = ST_CLEAR;
					default:    state_d = ST_FIN;
				endcase
			end
			ST_SCAN: begin
				cmd.rd_en = 1'b1;
				cmd.addr  = scan_q;
				cmd.kind  = kind_q;
				if (last) begin
					scan_d  = '0;
					state_d = ST_DRAIN;
				end else begin
					scan_d = scan_q + 1'b1;
				end
			end
			ST_DRAIN: begin
				unique case (kind_q)
					KIND_FIND:  state_d = (sts.mode == MODE_ADD) ? ST_APPLY : ST_FIN;
					KIND_SWEEP: state_d = ST_COMMIT;
					KIND_MIN:   state_d = ST_HTARGET;
					default:    state_d = ST_FIN;
				endcase
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = ST_FIN;
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = (sts.mode == MODE_AGE) ? ST_FIN : ST_HCHECK;
			end
			ST_HCHECK: begin
				if (!sts.over) begin
					state_d = ST_FIN;
				end else if (!sts.off_zero) begin
					cmd.set_heur  = 1'b1;
					cmd.scan_init = 1'b1;
					kind_d        = KIND_SWEEP;
					state_d       = ST_SCAN;
				end else if (sts.ac_max) begin
					state_d = ST_FIN;
				end else begin
					cmd.scan_init = 1'b1;
					kind_d        = KIND_MIN;
					state_d       = ST_SCAN;
				end
			end
			ST_HTARGET: begin
				cmd.set_heur  = 1'b1;
				cmd.scan_init = 1'b1;
				kind_d        = KIND_SWEEP;
				state_d       = ST_SCAN;
			end
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				cmd.addr   = scan_q;
				if (last) begin
					cmd.clear_commit = 1'b1;
					scan_d           = '0;
					state_d          = ST_FIN;
				end else begin
					scan_d = scan_q + 1'b1;
				end
			end
			ST_FIN: begin
				if (!sts.rsp_busy) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

>>> design/vrt_dp.sv
// Datapath for the visit record table: entry memory, scan accumulators, result register.
module vrt_dp
	import vrt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	output dp_sts_t              sts,
	input  req_t                 req,
	input  logic                 cfg_wr,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp
);

	localparam logic [TIME_W-1:0] T_MAX = '1;

	entry_t mem [CAPACITY];

	logic [MAX_W-1:0]     max_q;
	logic [TIME_W-1:0]    thr_q;
	req_t                 item_q;
	logic [OCC_W-1:0]     occ_q;
	logic [TIME_W-1:0]    ac_q;
	logic [REMOVED_W-1:0] total_q;
	logic [OCC_W-1:0]     n_q;
	logic                 match_q, free_q, full_q;
	logic [ADDR_W-1:0]    midx_q, fidx_q;
	entry_t               ent_q;
	entry_t               rd_q;
	scan_kind_t           kind_s1;
	logic [ADDR_W-1:0]    addr_s1;
	logic [TIME_W:0]      min_q;
	logic [TIME_W-1:0]    target_q;
	rsp_t                 rsp_q;
	logic                 rsp_valid_q;

	logic [KEY_BITS-1:0]  key;
	logic                 sweep_hit, add_ok;
	logic [TIME_W-1:0]    gap, off, heur_target;
	logic [TIME_W:0]      ac_inc, mmax, la_inc;
	entry_t               upd, fresh, new_ent, wr_data;
	logic                 wr_en;
	logic [ADDR_W-1:0]    wr_addr;
	logic [SIZE_W-1:0]    stored, size_diff;
	rsp_t                 res;

	function automatic logic [TIME_W-1:0] sat_inc(logic [TIME_W-1:0] v);
		return (v == T_MAX) ? v : v + 1'b1;
	endfunction

	assign key       = item_q.fingerprint[KEY_BITS-1:0];
	assign sweep_hit = (kind_s1 == KIND_SWEEP) && rd_q.valid && (rd_q.access_time < target_q);
	assign la_inc    = {1'b0, rd_q.access_time} + 1'b1;
	assign add_ok    = match_q || (free_q && ({21'd0, occ_q} < {21'd0, max_q} + 32'd0));

	// Heuristic cutoff step
	always_comb begin
		gap    = (item_q.now > ac_q) ? item_q.now - ac_q : '0;
		off    = gap >> 2;
		ac_inc = {1'b0, ac_q} + 1'b1;
		mmax   = (min_q < ac_inc) ? ac_inc : min_q;
		if (off != '0)
			heur_target = ac_q + off;
		else if (mmax[TIME_W])
			heur_target = T_MAX;
		else
			heur_target = mmax[TIME_W-1:0];
	end

	// Status to the sequencer
	always_comb begin
		sts.mode     = item_q.mode;
		sts.cut_gt   = item_q.cutoff > ac_q;
		sts.over     = (32'(occ_q) * 32'd10) > (32'(max_q) * 32'd9);
		sts.off_zero = (off == '0);
		sts.ac_max   = (ac_q == T_MAX);
		sts.rsp_busy = rsp_valid_q && rsp_stall;
	end

	// Updated and fresh entries for an add
	always_comb begin
		stored = item_q.content_known ? item_q.content_size : '1;
		size_diff = (ent_q.last_size > item_q.content_size) ?
			ent_q.last_size - item_q.content_size : item_q.content_size - ent_q.last_size;
		upd             = ent_q;
		upd.access_time = item_q.now;
		upd.access_count = sat_inc(ent_q.access_count);
		if (!item_q.write_known) begin
			if (item_q.content_known && (size_diff > {16'd0, thr_q})) begin
				upd.change_count = sat_inc(ent_q.change_count);
				upd.last_size    = item_q.content_size;
				upd.change_time  = item_q.modified_known ? item_q.modified_time : item_q.now;
			end
		end else if (ent_q.change_time != item_q.write_time) begin
			upd.change_count = sat_inc(ent_q.change_count);
			upd.last_size    = stored;
			upd.change_time  = item_q.write_time;
		end
		fresh.valid        = 1'b1;
		fresh.key          = key;
		fresh.first_seen   = item_q.now;
		fresh.access_time  = item_q.now;
		fresh.access_count = 32'd1;
		fresh.change_count = 32'd1;
		fresh.last_size    = stored;
		fresh.change_time  = item_q.write_known ? item_q.write_time :
			(item_q.modified_known ? item_q.modified_time : item_q.now);
		new_ent = match_q ? upd : fresh;
	end

	// Memory write port select
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cmd.addr;
		wr_data = '0;
		if (cmd.clr_wr) begin
			wr_en = 1'b1;
		end else if (sweep_hit) begin
			wr_en         = 1'b1;
			wr_addr       = addr_s1;
			wr_data       = rd_q;
			wr_data.valid = 1'b0;
		end else if (cmd.apply && add_ok) begin
			wr_en   = 1'b1;
			wr_addr = match_q ? midx_q : fidx_q;
			wr_data = new_ent;
		end
	end

	// Entry memory
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (cmd.rd_en)
			rd_q <= mem[cmd.addr];
	end

	// Result assembly
	always_comb begin
		res = '0;
		case (item_q.mode)
			MODE_ADD: begin
				if (full_q) begin
					res.status = STATUS_FULL;
				end else begin
					res.first_seen   = ent_q.first_seen;
					res.access_time  = ent_q.access_time;
					res.access_count = ent_q.access_count;
					res.change_count = ent_q.change_count;
					res.change_time  = ent_q.change_time;
					res.last_size    = ent_q.last_size;
				end
			end
			MODE_LOOKUP: begin
				if (!match_q) begin
					res.status = STATUS_NOTFOUND;
				end else begin
					res.first_seen   = ent_q.first_seen;
					res.access_time  = ent_q.access_time;
					res.access_count = ent_q.access_count;
					res.change_count = ent_q.change_count;
					res.change_time  = ent_q.change_time;
					res.last_size    = ent_q.last_size;
				end
			end
			MODE_AGE, MODE_HEUR: res.removed_count = total_q;
			default: res = '0;
		endcase
	end

	// Payload registers: item, captured entry, cutoff target, result
	always_ff @(posedge clk) begin
		if (cmd.load)
			item_q <= req;
		if (cmd.set_cut)
			target_q <= item_q.cutoff;
		else if (cmd.set_heur)
			target_q <= heur_target;
		if (kind_s1 == KIND_FIND && rd_q.valid && rd_q.key == key && !match_q)
			ent_q <= rd_q;
		else if (cmd.apply && add_ok)
			ent_q <= new_ent;
		if (cmd.finish)
			rsp_q <= res;
	end

	// Control state: configuration, occupancy, cutoff, scan accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q       <= MAX_W'(1024);
			thr_q       <= '0;
			occ_q       <= '0;
			ac_q        <= '0;
			total_q     <= '0;
			n_q         <= '0;
			match_q     <= 1'b0;
			free_q      <= 1'b0;
			full_q      <= 1'b0;
			midx_q      <= '0;
			fidx_q      <= '0;
			min_q       <= '0;
			kind_s1     <= KIND_NONE;
			addr_s1     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (cfg_index)
					CFG_MAX_ENTRIES: max_q <= cfg_data[MAX_W-1:0];
					CFG_CHANGE_THR:  thr_q <= cfg_data;
					default: ;
				endcase
			end
			kind_s1 <= cmd.rd_en ? cmd.kind : KIND_NONE;
			addr_s1 <= cmd.addr;
			if (cmd.load)
				total_q <= '0;
			if (cmd.scan_init) begin
				match_q <= 1'b0;
				free_q  <= 1'b0;
				n_q     <= '0;
				min_q   <= {1'b1, {TIME_W{1'b0}}};
			end else begin
				// fold in the entry read on the previous cycle
				if (kind_s1 == KIND_FIND) begin
					if (rd_q.valid && rd_q.key == key && !match_q) begin
						match_q <= 1'b1;
						midx_q  <= addr_s1;
					end
					if (!rd_q.valid && !free_q) begin
						free_q <= 1'b1;
						fidx_q <= addr_s1;
					end
				end
				if (sweep_hit)
					n_q <= n_q + 1'b1;
				if (kind_s1 == KIND_MIN && rd_q.valid && la_inc < min_q)
					min_q <= la_inc;
			end
			if (cmd.commit) begin
				occ_q   <= occ_q - n_q;
				ac_q    <= target_q;
				total_q <= total_q + REMOVED_W'(n_q);
			end
			if (cmd.apply) begin
				full_q <= !add_ok;
				if (add_ok && !match_q)
					occ_q <= occ_q + 1'b1;
			end
			if (cmd.clear_commit) begin
				occ_q <= '0;
				ac_q  <= item_q.now;
			end
			if (cmd.finish)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> design/visit_record_table_with_aging_core.sv
// Top level of the visit record table with aging.
//
// Requests arrive on req (req_valid/req_stall); one result per request leaves on
// rsp (rsp_valid/rsp_stall). A transfer happens when valid is high and stall low.
// Configuration writes use cfg_valid/cfg_ready (always ready): index 0 sets
// max_entries, index 1 sets change_threshold; write them only while idle.
// One request is worked at a time. Add, lookup and age scan the whole entry
// memory through its single read port; an age with a cutoff not above the
// current one and undefined modes finish without a scan. Heuristic aging sweeps
// the memory once per cutoff step, first scanning for the oldest entry when the
// step would otherwise be zero. The input opens again in the same cycle that
// the predecessor's result is raised.
// After reset the block wipes all CAPACITY entries of the memory, one entry a
// cycle, holding req_stall high meanwhile.
// A finished result sits in the output register until taken; while rsp_stall
// is high the next request may already be accepted and worked, and its result
// waits until the register frees, with req_stall held high.
module visit_record_table_with_aging_core
	import vrt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign req_stall = !cmd.idle;
	assign cfg_ready = 1'b1;

	vrt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	vrt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// Never overwrite a result still waiting to be taken
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !(rsp_valid && rsp_stall))
		else $error("result overwritten while stalled");

	// Accepting a request closes the input until it is finished
	a_load_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> req_stall)
		else $error("input open after accepting a request");

	// Wipe writes and scan reads never share a cycle
	a_wipe_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_wr |-> !cmd.rd_en)
		else $error("memory wipe overlaps a scan");

endmodule

>>> tb/vrt_checker.sv
// Checker for the visit record table: watches all channels, predicts and compares results.
`timescale 1ns / 1ps
module vrt_checker
	import vrt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic                 req_stall,
	input  req_t                 req,
	input  logic                 rsp_valid,
	input  logic                 rsp_stall,
	input  rsp_t                 rsp,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   mismatches,
	output int                   waiting
);

	// Predicted table contents
	logic [CAPACITY-1:0] tbl_valid;
	logic [63:0]         tbl_key     [CAPACITY];
	logic [31:0]         tbl_first   [CAPACITY];
	logic [31:0]         tbl_access  [CAPACITY];
	logic [31:0]         tbl_acount  [CAPACITY];
	logic [31:0]         tbl_ccount  [CAPACITY];
	logic [31:0]         tbl_change  [CAPACITY];
	logic [47:0]         tbl_size    [CAPACITY];
	int unsigned         tbl_occ;
	logic [31:0]         tbl_cutoff;
	logic [MAX_W-1:0]    max_entries;
	logic [31:0]         change_thr;

	rsp_t results_due[$];

	function automatic int find_slot(logic [63:0] key);
		for (int i = 0; i < CAPACITY; i++)
			if (tbl_valid[i] && tbl_key[i] == key)
				return i;
		return -1;
	endfunction

	function automatic logic [31:0] bump(logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	// Drop entries last accessed before oldest and move the cutoff there
	function automatic int unsigned age_out(logic [31:0] oldest);
		int unsigned n;
		n = 0;
		for (int i = 0; i < CAPACITY; i++)
			if (tbl_valid[i] && tbl_access[i] < oldest) begin
				tbl_valid[i] = 1'b0;
				n++;
			end
		tbl_occ -= n;
		tbl_cutoff = oldest;
		return n;
	endfunction

	function automatic int unsigned heuristic_age(logic [31:0] now);
		int unsigned total;
		logic [31:0] gap, off, target;
		longint m;
		total = 0;
		while (longint'(tbl_occ) * 10 > longint'(max_entries) * 9) begin
			gap = (now > tbl_cutoff) ? now - tbl_cutoff : 32'd0;
			off = gap >> 2;
			if (off >= 1) begin
				target = tbl_cutoff + off;
			end else begin
				if (tbl_cutoff == 32'hFFFF_FFFF)
					break;
				m = 64'h1_0000_0000;
				for (int i = 0; i < CAPACITY; i++)
					if (tbl_valid[i] && longint'(tbl_access[i]) + 1 < m)
						m = longint'(tbl_access[i]) + 1;
				if (m < longint'(tbl_cutoff) + 1)
					m = longint'(tbl_cutoff) + 1;
				if (m > 64'hFFFF_FFFF)
					m = 64'hFFFF_FFFF;
				target = m[31:0];
			end
			total += age_out(target);
		end
		return total;
	endfunction

	function automatic rsp_t entry_fields(int i);
		rsp_t o;
		o = '0;
		o.first_seen   = tbl_first[i];
		o.access_time  = tbl_access[i];
		o.access_count = tbl_acount[i];
		o.change_count = tbl_ccount[i];
		o.change_time  = tbl_change[i];
		o.last_size    = tbl_size[i];
		return o;
	endfunction

	// Work out the result of one request and update the predicted table
	function automatic rsp_t table_result(req_t r);
		rsp_t o;
		int i;
		logic [47:0] stored, s, d;
		o = '0;
		stored = r.content_known ? r.content_size : '1;
		case (r.mode)
			MODE_ADD: begin
				i = find_slot(r.fingerprint);
				if (i < 0) begin
					if (tbl_occ >= max_entries) begin
						o.status = STATUS_FULL;
						return o;
					end
					for (i = 0; i < CAPACITY; i++)
						if (!tbl_valid[i])
							break;
					if (i >= CAPACITY) begin
						o.status = STATUS_FULL;
						return o;
					end
					tbl_valid[i]  = 1'b1;
					tbl_key[i]    = r.fingerprint;
					tbl_first[i]  = r.now;
					tbl_access[i] = r.now;
					tbl_acount[i] = 32'd1;
					tbl_ccount[i] = 32'd1;
					tbl_size[i]   = stored;
					tbl_change[i] = r.write_known ? r.write_time :
						(r.modified_known ? r.modified_time : r.now);
					tbl_occ++;
				end else begin
					tbl_access[i] = r.now;
					tbl_acount[i] = bump(tbl_acount[i]);
					if (!r.write_known) begin
						s = tbl_size[i];
						d = (s > r.content_size) ? s - r.content_size : r.content_size - s;
						if (r.content_known && d > {16'd0, change_thr}) begin
							tbl_ccount[i] = bump(tbl_ccount[i]);
							tbl_size[i]   = r.content_size;
							tbl_change[i] = r.modified_known ? r.modified_time : r.now;
						end
					end else if (tbl_change[i] != r.write_time) begin
						tbl_ccount[i] = bump(tbl_ccount[i]);
						tbl_size[i]   = stored;
						tbl_change[i] = r.write_time;
					end
				end
				o = entry_fields(i);
			end
			MODE_LOOKUP: begin
				i = find_slot(r.fingerprint);
				if (i < 0)
					o.status = STATUS_NOTFOUND;
				else
					o = entry_fields(i);
			end
			MODE_AGE: begin
				if (r.cutoff > tbl_cutoff)
					o.removed_count = REMOVED_W'(age_out(r.cutoff));
			end
			MODE_HEUR: begin
				o.removed_count = REMOVED_W'(heuristic_age(r.now));
			end
			MODE_CLEAR: begin
				tbl_valid  = '0;
				tbl_occ    = 0;
				tbl_cutoff = r.now;
			end
			default: ;
		endcase
		return o;
	endfunction

	// Track config writes, predict on request transfer, compare on result transfer
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			tbl_valid   = '0;
			tbl_occ     = 0;
			tbl_cutoff  = '0;
			max_entries = MAX_W'(1024);
			change_thr  = '0;
			mismatches  <= 0;
			results_due.delete();
			waiting     <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_MAX_ENTRIES)
					max_entries = cfg_data[MAX_W-1:0];
				else if (cfg_index == CFG_CHANGE_THR)
					change_thr = cfg_data;
			end
			if (rsp_valid && !rsp_stall) begin
				if (results_due.size() == 0) begin
					if (mismatches < 10)
						$display("[%0t] unexpected result %p", $time, rsp);
					mismatches <= mismatches + 1;
				end else begin
					want = results_due.pop_front();
					if (rsp !== want) begin
						if (mismatches < 10) begin
							$display("[%0t] result mismatch", $time);
							$display("  exp st=%0d fs=%h la=%h ac=%h cc=%h lc=%h sz=%h rm=%0d",
								want.status, want.first_seen, want.access_time,
								want.access_count, want.change_count, want.change_time,
								want.last_size, want.removed_count);
							$display("  got st=%0d fs=%h la=%h ac=%h cc=%h lc=%h sz=%h rm=%0d",
								rsp.status, rsp.first_seen, rsp.access_time,
								rsp.access_count, rsp.change_count, rsp.change_time,
								rsp.last_size, rsp.removed_count);
						end
						mismatches <= mismatches + 1;
					end
				end
			end
			if (req_valid && !req_stall)
				results_due.insert(results_due.size(), table_result(req));
			waiting <= results_due.size();
		end
	end

endmodule

>>> tb/tb.sv
// Testbench top for the visit record table: stimulus, idling, pressure and verdict.
`timescale 1ns / 1ps
module tb;
	import vrt_pkg::*;

	localparam int LIMIT       = 20_000_000;
	localparam int HOLD_CYCLES = 4 * CAPACITY;
	localparam int PHASE_ITEMS = 270;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	req_t                 req = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	rsp_t                 rsp;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	int                   mismatches, waiting;

	int          tx_idle_pct = 0;
	int          rx_stall_pct = 0;
	logic        hold_go = 1'b0;
	int          hold_left = 0;
	bit          hold_done = 1'b0;
	int          cycles = 0;
	int          sent = 0;
	logic [31:0] tnow = 32'd1000;
	logic [63:0] key_pool [12];

	always #5 clk = ~clk;

	visit_record_table_with_aging_core uut (.*);

	vrt_checker chk (.*);

	// Receiver: random stalls, plus one long hold-off
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else if (hold_go && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < rx_stall_pct);
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL");
			$finish;
		end
	end

	task automatic send(input req_t r);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sent++;
	endtask

	// Pause the sender until every result is back, then let the block settle
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic req_t make_req(logic [2:0] mode, logic [63:0] key);
		req_t r;
		r = '0;
		r.mode        = mode;
		r.fingerprint = key;
		r.now         = tnow;
		return r;
	endfunction

	function automatic logic [31:0] near_time();
		case ($urandom_range(3))
			0: return $urandom;
			1: return tnow - $urandom_range(0, 300);
			default: return tnow - $urandom_range(0, 3);
		endcase
	endfunction

	// Random request: mostly adds and lookups on a small key pool
	function automatic req_t random_req();
		req_t r;
		int pick;
		r = '0;
		pick = $urandom_range(99);
		if (pick < 55)      r.mode = MODE_ADD;
		else if (pick < 78) r.mode = MODE_LOOKUP;
		else if (pick < 87) r.mode = MODE_AGE;
		else if (pick < 91) r.mode = MODE_HEUR;
		else if (pick < 94) r.mode = MODE_CLEAR;
		else                r.mode = 3'($urandom_range(5, 7));
		if ($urandom_range(9) == 0)
			r.fingerprint = {$urandom, $urandom};
		else
			r.fingerprint = key_pool[$urandom_range(11)];
		if ($urandom_range(2) == 0)
			r.content_size = 48'({$urandom, $urandom});
		else
			r.content_size = 48'($urandom_range(0, 400));
		r.content_known  = ($urandom_range(4) != 0);
		r.modified_time  = near_time();
		r.modified_known = 1'($urandom_range(1));
		r.write_time     = near_time();
		r.write_known    = 1'($urandom_range(1));
		if ($urandom_range(19) == 0)
			tnow = $urandom;
		else
			tnow = tnow + $urandom_range(0, 40);
		r.now = tnow;
		r.cutoff = ($urandom_range(7) == 0) ? 32'($urandom) : tnow - $urandom_range(0, 200);
		return r;
	endfunction

	initial begin
		req_t r;
		for (int i = 0; i < 12; i++)
			key_pool[i] = {$urandom, $urandom};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with a three-entry table
		write_reg(CFG_MAX_ENTRIES, 32'd3);
		write_reg(CFG_CHANGE_THR, 32'd0);
		r = make_req(MODE_ADD, '1);
		r.content_size = '1; r.content_known = 1'b1;
		send(r);                                         // new entry, max size
		r = make_req(MODE_ADD, '0);
		r.content_known = 1'b0; r.modified_time = 32'd77; r.modified_known = 1'b1;
		send(r);                                         // unknown size, modified time
		r = make_req(MODE_ADD, 64'h5555_AAAA_5555_AAAA);
		r.write_time = '1; r.write_known = 1'b1; r.content_size = 48'd10;
		r.content_known = 1'b1;
		send(r);                                         // write time taken
		send(make_req(MODE_ADD, 64'h1234));              // table full
		tnow = tnow + 5;
		r = make_req(MODE_ADD, '0);
		r.content_size = '0; r.content_known = 1'b1;
		send(r);                                         // change from unknown marker
		r = make_req(MODE_ADD, 64'h5555_AAAA_5555_AAAA);
		r.write_time = '1; r.write_known = 1'b1;
		send(r);                                         // same write time, no change
		r.write_time = '0;
		send(r);                                         // new write time
		send(make_req(MODE_LOOKUP, '1));
		send(make_req(MODE_LOOKUP, 64'h1234));           // miss
		send(make_req(3'd5, '1));
		send(make_req(3'd7, '0));
		r = make_req(MODE_AGE, '0); r.cutoff = '0;
		send(r);                                         // cutoff not above
		send(make_req(MODE_HEUR, '0));                   // three of three: steps down
		r = make_req(MODE_CLEAR, '0); r.now = '1;
		send(r);
		send(make_req(MODE_ADD, 64'hFEED));
		send(make_req(MODE_ADD, 64'hBEEF));
		send(make_req(MODE_ADD, 64'hCAFE));
		send(make_req(MODE_HEUR, '0));                   // cutoff at its top: nothing removed
		r = make_req(MODE_AGE, '0); r.cutoff = '1;
		send(r);
		send(make_req(MODE_LOOKUP, 64'hFEED));
		drain();

		// Random phases, each with its own register settings and idling
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin write_reg(CFG_MAX_ENTRIES, 32'd1024); write_reg(CFG_CHANGE_THR, 32'd0); end
				1: begin write_reg(CFG_MAX_ENTRIES, 32'd1); write_reg(CFG_CHANGE_THR, '1); end
				2: begin write_reg(CFG_MAX_ENTRIES, 32'd8); write_reg(CFG_CHANGE_THR, 32'd100); end
				default: begin write_reg(CFG_MAX_ENTRIES, 32'd10); write_reg(CFG_CHANGE_THR, 32'd3); end
			endcase
			tx_idle_pct  = (ph == 1) ? 63 : (ph == 3) ? 6 : 0;
			rx_stall_pct = (ph == 2) ? 63 : (ph == 3) ? 6 : 0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 0 && n == 10)
					hold_go <= 1'b1;
				send(random_req());
			end
			drain();
		end

		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		$display("ran %0d requests over %0d cycles: all modes, full table, aging and clear,",
			sent, cycles);
		$display("four register settings, idle and stall mixes and one long output hold-off");
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
